// ===== rtl/core/mfde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_pkg: shared types and codes of the frame store drawing engine
// Request and pen codes, the queued command beat and the default panel size.
// ----------------------------------------------------------------------------
package mfde_pkg;

    // Default panel geometry in pixels.
    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;

    // Request codes on the command port.
    localparam logic [1:0] REQ_PLOT = 2'd0;
    localparam logic [1:0] REQ_LINE = 2'd1;
    localparam logic [1:0] REQ_FILL = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    // Pen codes; the last one leaves the store untouched.
    localparam logic [1:0] PEN_SET    = 2'd0;
    localparam logic [1:0] PEN_ERASE  = 2'd1;
    localparam logic [1:0] PEN_INVERT = 2'd2;
    localparam logic [1:0] PEN_KEEP   = 2'd3;

    // Command queue between the front and back parts.
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Kind of work that the back part carries out.
    typedef enum logic [1:0] {
        KIND_WALK,
        KIND_FILL,
        KIND_READ
    } t_kind;

    // One classified command beat.
    typedef struct packed {
        t_kind      kind;
        logic       walk_rows;  // step along rows at a fixed column
        logic       use_div;    // sloped line: slope step needs dividing
        logic       slope_neg;  // per-column step of the row is negative
        logic       rd_zero;    // read outside the panel returns zero
        logic [7:0] col;        // first column, or column to read
        logic [7:0] row;        // first row, or page to read
        logic [7:0] last;       // last column or last row of the walk
        logic [7:0] dvd;        // magnitude of the row difference
        logic [7:0] dvs;        // magnitude of the column difference
        logic [1:0] pen;
    } t_cmd;

endpackage

// ===== rtl/core/mfde_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_front: command classifier
// Turns an accepted command into a walk, fill or read beat for the queue and
// drops commands whose pen leaves the store unchanged.
// ----------------------------------------------------------------------------
module mfde_front #(
    parameter int PANEL_WIDTH  = mfde_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfde_pkg::DEF_PANEL_HEIGHT
) (
    input  logic          i_accept,
    input  logic [1:0]    i_req_type,
    input  logic [7:0]    i_x_start,
    input  logic [7:0]    i_y_start,
    input  logic [7:0]    i_x_end,
    input  logic [7:0]    i_y_end,
    input  logic [1:0]    i_pen,
    output logic          o_push,
    output mfde_pkg::t_cmd o_cmd
);
    import mfde_pkg::*;

    localparam int PAGES = (PANEL_HEIGHT + 7) / 8;

    logic       x_eq;
    logic       y_eq;
    logic       x_lt;
    logic       y_lt;
    logic [7:0] lo_x;
    logic [7:0] hi_x;
    logic       no_change;

    // Orderings of the two end points.
    assign x_eq = (i_x_start == i_x_end);
    assign y_eq = (i_y_start == i_y_end);
    assign x_lt = (i_x_start < i_x_end);
    assign y_lt = (i_y_start < i_y_end);
    assign lo_x = x_lt ? i_x_start : i_x_end;
    assign hi_x = x_lt ? i_x_end : i_x_start;

    // Drawing with the unused pen code is accepted but does nothing.
    assign no_change = (i_pen == PEN_KEEP) && (i_req_type != REQ_READ);
    assign o_push    = i_accept && !no_change;

    // Classify the request.
    always_comb begin
        o_cmd           = '0;
        o_cmd.kind      = KIND_WALK;
        o_cmd.col       = i_x_start;
        o_cmd.row       = i_y_start;
        o_cmd.last      = i_x_start;
        o_cmd.pen       = i_pen;
        unique case (i_req_type)
            REQ_PLOT: begin
                o_cmd.kind = KIND_WALK;
            end
            REQ_LINE: begin
                if (y_eq) begin
                    // Horizontal line, or a single point.
                    o_cmd.col  = lo_x;
                    o_cmd.last = hi_x;
                end else if (x_eq) begin
                    // Vertical line walks the rows.
                    o_cmd.walk_rows = 1'b1;
                    o_cmd.row       = y_lt ? i_y_start : i_y_end;
                    o_cmd.last      = y_lt ? i_y_end : i_y_start;
                end else begin
                    // Sloped line walks the columns from the left end.
                    o_cmd.use_div   = 1'b1;
                    o_cmd.col       = lo_x;
                    o_cmd.last      = hi_x;
                    o_cmd.row       = x_lt ? i_y_start : i_y_end;
                    o_cmd.dvd       = y_lt ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
                    o_cmd.dvs       = hi_x - lo_x;
                    o_cmd.slope_neg = y_lt ^ x_lt;
                end
            end
            REQ_FILL: begin
                o_cmd.kind = KIND_FILL;
            end
            REQ_READ: begin
                o_cmd.kind    = KIND_READ;
                o_cmd.rd_zero = ({1'b0, i_x_start} >= 9'(PANEL_WIDTH))
                             || ({1'b0, i_y_start} >= 9'(PAGES));
            end
            default: begin
                o_cmd.kind = KIND_WALK;
            end
        endcase
    end

endmodule

// ===== rtl/core/mfde_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_queue: command queue
// A short first-in first-out buffer of classified command beats between the
// front and back parts.
// ----------------------------------------------------------------------------
module mfde_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfde_pkg::t_cmd i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output mfde_pkg::t_cmd o_data
);
    import mfde_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/mfde_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_back: drawing executor and frame store
// Clears the store after reset, then takes command beats from the queue and
// carries out point walks, whole-store fills and byte reads on the store.
// ----------------------------------------------------------------------------
module mfde_back #(
    parameter int PANEL_WIDTH  = mfde_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfde_pkg::DEF_PANEL_HEIGHT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  mfde_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_read_strobe,
    output logic [7:0]     o_read_byte
);
    import mfde_pkg::*;

    localparam int PAGES     = (PANEL_HEIGHT + 7) / 8;
    localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W     = $clog2(PANEL_WIDTH);
    localparam int ADDR_W    = COL_W + PAGE_W;
    localparam int DEPTH     = PANEL_WIDTH * (1 << PAGE_W);
    localparam int DIV_STEPS = 8;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_DIV_FIX,
        ST_PT_RD,
        ST_PT_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_RD_OUT
    } t_state;

    // Apply a pen to the bits of a byte selected by a mask.
    function automatic logic [7:0] apply_pen(input logic [7:0] data, input logic [7:0] mask,
                                             input logic [1:0] pen);
        logic [7:0] res;
        res = data;
        case (pen)
            PEN_SET:    res = data | mask;
            PEN_ERASE:  res = data & ~mask;
            PEN_INVERT: res = data ^ mask;
            default:    res = data;
        endcase
        return res;
    endfunction

    // Frame store.
    logic [7:0]        r_store [DEPTH];
    logic [7:0]        r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Sequencer state.
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [7:0]        r_col, n_col;
    logic [7:0]        r_row, n_row;
    logic [7:0]        r_last, n_last;
    logic              r_rows, n_rows;
    logic [1:0]        r_pen, n_pen;
    logic [7:0]        r_mask, n_mask;
    logic [7:0]        r_qs, n_qs;
    logic [7:0]        r_rs, n_rs;
    logic [7:0]        r_rem, n_rem;
    logic [7:0]        r_dvs, n_dvs;
    logic [7:0]        r_dq, n_dq;
    logic [7:0]        r_drem, n_drem;
    logic              r_neg, n_neg;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_rdz, n_rdz;
    logic              r_strobe, n_strobe;
    logic [7:0]        r_byte, n_byte;

    // Datapath helpers.
    logic              pt_in;
    logic [ADDR_W-1:0] pt_addr;
    logic [8:0]        rsum;
    logic              carry;
    logic              walk_done;
    logic [8:0]        rem2;
    logic              div_ge;
    logic              r0_nz;

    assign pt_in   = ({1'b0, r_col} < 9'(PANEL_WIDTH)) && ({1'b0, r_row} < 9'(PANEL_HEIGHT));
    assign pt_addr = {r_col[COL_W-1:0], r_row[3 +: PAGE_W]};

    // Remainder step of the column walk.
    assign rsum  = {1'b0, r_rem} + {1'b0, r_rs};
    assign carry = (rsum >= {1'b0, r_dvs});
    assign walk_done = r_rows ? (r_row == r_last) : (r_col == r_last);

    // One restoring division step.
    assign rem2   = {r_drem, r_dq[7]};
    assign div_ge = (rem2 >= {1'b0, r_dvs});
    assign r0_nz  = (r_drem != 8'h00);

    assign o_pop         = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_clearing    = (r_state == ST_CLEAR);
    assign o_read_strobe = r_strobe;
    assign o_read_byte   = r_byte;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_col     = r_col;
        n_row     = r_row;
        n_last    = r_last;
        n_rows    = r_rows;
        n_pen     = r_pen;
        n_mask    = r_mask;
        n_qs      = r_qs;
        n_rs      = r_rs;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_dq      = r_dq;
        n_drem    = r_drem;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_rdz     = r_rdz;
        n_strobe  = 1'b0;
        n_byte    = r_byte;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = 8'h00;
        mem_re    = 1'b0;
        mem_raddr = pt_addr;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_col  = i_cmd.col;
                    n_row  = i_cmd.row;
                    n_last = i_cmd.last;
                    n_rows = i_cmd.walk_rows;
                    n_pen  = i_cmd.pen;
                    n_rem  = 8'h00;
                    unique case (i_cmd.kind)
                        KIND_WALK: begin
                            if (i_cmd.use_div) begin
                                n_dq    = i_cmd.dvd;
                                n_drem  = 8'h00;
                                n_dvs   = i_cmd.dvs;
                                n_neg   = i_cmd.slope_neg;
                                n_cnt   = 3'd0;
                                n_state = ST_DIV;
                            end else begin
                                // No slope: the row never steps on a column.
                                n_qs    = 8'h00;
                                n_rs    = 8'h00;
                                n_dvs   = 8'h01;
                                n_state = ST_PT_RD;
                            end
                        end
                        KIND_FILL: begin
                            n_addr  = '0;
                            n_mask  = 8'hff;
                            n_state = ST_FILL_RD;
                        end
                        KIND_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = {i_cmd.col[COL_W-1:0], i_cmd.row[PAGE_W-1:0]};
                            n_rdz     = i_cmd.rd_zero;
                            n_state   = ST_RD_OUT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_dq   = {r_dq[6:0], div_ge};
                n_drem = div_ge ? 8'(rem2 - {1'b0, r_dvs}) : rem2[7:0];
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == 3'(DIV_STEPS - 1)) begin
                    n_state = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX: begin
                // Turn the magnitude quotient into a floored signed step.
                if (r_neg) begin
                    n_qs = 8'h00 - r_dq - {7'b0, r0_nz};
                    n_rs = r0_nz ? (r_dvs - r_drem) : 8'h00;
                end else begin
                    n_qs = r_dq;
                    n_rs = r_drem;
                end
                n_state = ST_PT_RD;
            end
            ST_PT_RD, ST_PT_WR: begin
                if ((r_state == ST_PT_RD) && pt_in) begin
                    mem_re  = 1'b1;
                    n_addr  = pt_addr;
                    n_mask  = 8'b1 << r_row[2:0];
                    n_state = ST_PT_WR;
                end else begin
                    if (r_state == ST_PT_WR) begin
                        mem_we    = 1'b1;
                        mem_wdata = apply_pen(r_rd_data, r_mask, r_pen);
                    end
                    // Step to the next point of the walk.
                    if (walk_done) begin
                        n_state = ST_IDLE;
                    end else if (r_rows) begin
                        n_row   = r_row + 1'b1;
                        n_state = ST_PT_RD;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_row   = r_row + r_qs + {7'b0, carry};
                        n_rem   = carry ? 8'(rsum - {1'b0, r_dvs}) : rsum[7:0];
                        n_state = ST_PT_RD;
                    end
                end
            end
            ST_FILL_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr;
                n_state   = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = apply_pen(r_rd_data, r_mask, r_pen);
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = ST_FILL_RD;
                end
            end
            ST_RD_OUT: begin
                n_strobe = 1'b1;
                n_byte   = r_rdz ? 8'h00 : r_rd_data;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_strobe <= n_strobe;
            r_col    <= n_col;
            r_row    <= n_row;
            r_last   <= n_last;
            r_rows   <= n_rows;
            r_pen    <= n_pen;
            r_mask   <= n_mask;
            r_qs     <= n_qs;
            r_rs     <= n_rs;
            r_rem    <= n_rem;
            r_dvs    <= n_dvs;
            r_dq     <= n_dq;
            r_drem   <= n_drem;
            r_neg    <= n_neg;
            r_cnt    <= n_cnt;
            r_rdz    <= n_rdz;
            r_byte   <= n_byte;
        end
    end

    // Store write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_store[mem_raddr];
        end
    end

endmodule

// ===== rtl/core/mono_framebuffer_draw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine: page-organised monochrome frame store
// After reset the store is cleared one byte a cycle, with busy held high; the
// reset is synchronous. With the back part idle, an accepted read beat passes
// the queue, the store's registered read port and the strobe register before
// o_read_strobe rises; the receiver cannot stall. Work is bound by the store's
// single read-modify-write: each point and fill byte is read, then written, and
// a sloped line first runs a slope division. Two beats queue meanwhile.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
    parameter int PANEL_WIDTH  = mfde_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfde_pkg::DEF_PANEL_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_x_start,
    input  logic [7:0] i_y_start,
    input  logic [7:0] i_x_end,
    input  logic [7:0] i_y_end,
    input  logic [1:0] i_pen,
    output logic       o_read_strobe,
    output logic [7:0] o_read_byte
);
    import mfde_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    logic clearing;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Commands are taken unless the queue is full or the store is clearing.
    assign busy = clearing || q_full;

    // Front part: classify the accepted beat.
    mfde_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_accept   (start && !busy),
        .i_req_type (i_req_type),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .i_pen      (i_pen),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Queue between the two parts.
    mfde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_cmd)
    );

    // Back part: carry out the work on the store.
    mfde_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_read_strobe (o_read_strobe),
        .o_read_byte   (o_read_byte)
    );

endmodule
